FILE: rtl/core/ssg_pkg.sv
// ----------------------------------------------------------------------------
// ssg_pkg: shared types and constants for the Sierpinski leaf generator
// Vertex and triangle types, pipeline item type, child and face codes,
// base-3 power helper, midpoint and face normal functions.
// ----------------------------------------------------------------------------
package ssg_pkg;

  localparam int MAX_DEPTH = 6;
  localparam int COORD_W   = 16;
  localparam int DEPTH_W   = 3;
  localparam int IDX_W     = 10;
  localparam int FACE_W    = 2;
  localparam int NRM_W     = 2;
  localparam int DSAT_W    = $clog2(MAX_DEPTH + 1);

  localparam int GEOM_W      = 9 * COORD_W;
  localparam int IN_BITS     = GEOM_W + DEPTH_W + IDX_W + FACE_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = GEOM_W + 3 * NRM_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_PAD     = OUT_TDATA_W - OUT_BITS;

  localparam logic [1:0] CHILD_TOP   = 2'd0;
  localparam logic [1:0] CHILD_LEFT  = 2'd1;
  localparam logic [1:0] CHILD_RIGHT = 2'd2;

  localparam logic [FACE_W-1:0] FACE_RIGHT = 2'd0;
  localparam logic [FACE_W-1:0] FACE_FRONT = 2'd1;
  localparam logic [FACE_W-1:0] FACE_LEFT  = 2'd2;
  localparam logic [FACE_W-1:0] FACE_BACK  = 2'd3;

  localparam logic signed [NRM_W-1:0] NRM_POS  = 2'sb01;
  localparam logic signed [NRM_W-1:0] NRM_ZERO = 2'sb00;
  localparam logic signed [NRM_W-1:0] NRM_NEG  = 2'sb11;

  // first member sits in the high bits, so x lands lowest
  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } vec_t;

  typedef struct packed {
    vec_t r;
    vec_t l;
    vec_t t;
  } geom_t;

  typedef struct packed {
    logic signed [NRM_W-1:0] z;
    logic signed [NRM_W-1:0] y;
    logic signed [NRM_W-1:0] x;
  } nrm_t;

  typedef struct packed {
    geom_t              geom;
    logic [IDX_W-1:0]   rem;
    logic [DSAT_W-1:0]  dsat;
    logic [FACE_W-1:0]  face;
  } stage_t;

  function automatic int pow3(input int n);
    int p;
    p = 1;
    for (int k = 0; k < n; k++) p = p * 3;
    return p;
  endfunction

  function automatic logic signed [COORD_W-1:0] mid1(input logic signed [COORD_W-1:0] a,
                                                     input logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] s;
    s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    return s[COORD_W:1];
  endfunction

  function automatic vec_t mid_vec(input vec_t a, input vec_t b);
    vec_t m;
    m.x = mid1(a.x, b.x);
    m.y = mid1(a.y, b.y);
    m.z = mid1(a.z, b.z);
    return m;
  endfunction

  function automatic nrm_t face_normal(input logic [FACE_W-1:0] face);
    nrm_t n;
    n.y = NRM_POS;
    case (face)
      FACE_RIGHT: begin
        n.x = NRM_POS;
        n.z = NRM_ZERO;
      end
      FACE_FRONT: begin
        n.x = NRM_ZERO;
        n.z = NRM_POS;
      end
      FACE_LEFT: begin
        n.x = NRM_NEG;
        n.z = NRM_ZERO;
      end
      FACE_BACK: begin
        n.x = NRM_ZERO;
        n.z = NRM_NEG;
      end
      default: begin
        n.x = NRM_ZERO;
        n.z = NRM_ZERO;
      end
    endcase
    return n;
  endfunction

endpackage

FILE: rtl/core/ssg_levels.sv
// ----------------------------------------------------------------------------
// ssg_levels: subdivision level pipeline
// One register stage per level. Stage s resolves base-3 digit at weight
// 3^(MAX_DEPTH-1-s); items of lower depth pass the leading stages unchanged.
// ----------------------------------------------------------------------------
module ssg_levels (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  ssg_pkg::stage_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output ssg_pkg::stage_t out_data
);
  import ssg_pkg::*;

  stage_t src_dat [MAX_DEPTH+1];
  logic   src_vld [MAX_DEPTH+1];
  logic   rdy     [MAX_DEPTH+1];

  assign src_dat[0]     = in_data;
  assign src_vld[0]     = in_valid;
  assign rdy[MAX_DEPTH] = out_ready;
  assign in_ready       = rdy[0];
  assign out_valid      = src_vld[MAX_DEPTH];
  assign out_data       = src_dat[MAX_DEPTH];

  for (genvar s = 0; s < MAX_DEPTH; s++) begin : g_lvl
    localparam int P     = pow3(MAX_DEPTH - 1 - s);
    localparam int MIN_D = MAX_DEPTH - s;

    stage_t     st_r;
    stage_t     st_nxt;
    logic       vld_r;
    logic [1:0] digit;
    logic       active;
    vec_t       mlt;
    vec_t       mrt;
    vec_t       mlr;

    always_comb begin
      if (32'(src_dat[s].rem) >= 32'(2 * P)) begin
        digit = CHILD_RIGHT;
      end else if (32'(src_dat[s].rem) >= 32'(P)) begin
        digit = CHILD_LEFT;
      end else begin
        digit = CHILD_TOP;
      end
      active = 32'(src_dat[s].dsat) >= 32'(MIN_D);
      mlt = mid_vec(src_dat[s].geom.l, src_dat[s].geom.t);
      mrt = mid_vec(src_dat[s].geom.r, src_dat[s].geom.t);
      mlr = mid_vec(src_dat[s].geom.l, src_dat[s].geom.r);

      st_nxt = src_dat[s];
      case (digit)
        CHILD_RIGHT: st_nxt.rem = IDX_W'(32'(src_dat[s].rem) - 32'(2 * P));
        CHILD_LEFT:  st_nxt.rem = IDX_W'(32'(src_dat[s].rem) - 32'(P));
        default:     st_nxt.rem = src_dat[s].rem;
      endcase
      if (active) begin
        case (digit)
          CHILD_TOP: begin
            st_nxt.geom.l = mlt;
            st_nxt.geom.r = mrt;
          end
          CHILD_LEFT: begin
            st_nxt.geom.t = mlt;
            st_nxt.geom.r = mlr;
          end
          CHILD_RIGHT: begin
            st_nxt.geom.t = mrt;
            st_nxt.geom.l = mlr;
          end
          default: st_nxt.geom = src_dat[s].geom;
        endcase
      end
    end

    assign rdy[s]       = !vld_r || rdy[s+1];
    assign src_vld[s+1] = vld_r;
    assign src_dat[s+1] = st_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (rdy[s]) begin
        vld_r <= src_vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s] && src_vld[s]) begin
        st_r <= st_nxt;
      end
    end
  end

endmodule

FILE: rtl/core/sierpinski_subtriangle_generator_core.sv
// ----------------------------------------------------------------------------
// sierpinski_subtriangle_generator_core: Sierpinski gasket leaf generator
// Returns the leaf triangle of a root triangle picked by depth and index,
// plus the constant normal of the selected face.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per query: root triangle, depth, leaf index, face.
//           Depth saturates to MAX_DEPTH; an index at or above 3^depth is
//           clamped to the last leaf; depth zero returns the root.
//   out_* : one beat per query: leaf vertices and face normal, in order.
//   Pipeline: one clamp stage, then one register stage per subdivision level,
//           each doing a midpoint add/shift and a base-3 digit compare.
//   Throughput: one beat per cycle while out_tready is high.
//   Reset (rst_n low, synchronous) empties every stage; no other state.
//   Stall: with out_tready low the result holds; upstream stages keep
//           filling empty slots, so in_tready drops only once every stage
//           holds a beat. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module sierpinski_subtriangle_generator_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // low to high: top_x, top_y, top_z, left_vx, left_vy, left_vz,
  // right_vx, right_vy, right_vz, depth, leaf_index, face, zero pad
  input  logic [ssg_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // low to high: out_top_x, out_top_y, out_top_z, out_left_x, out_left_y,
  // out_left_z, out_right_x, out_right_y, out_right_z, normal_x, normal_y,
  // normal_z, zero pad
  output logic [ssg_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import ssg_pkg::*;

  localparam int PW_W = $clog2(pow3(MAX_DEPTH) + 1);

  logic [DEPTH_W-1:0] in_depth;
  logic [IDX_W-1:0]   in_idx;
  logic [DSAT_W-1:0]  dsat;
  logic [PW_W-1:0]    pw;
  stage_t             s0_nxt;
  stage_t             s0_r;
  logic               vld0_r;
  logic               lv_ready;
  logic               lv_valid;
  stage_t             lv_data;
  nrm_t               nrm;

  assign in_depth = in_tdata[GEOM_W +: DEPTH_W];
  assign in_idx   = in_tdata[GEOM_W + DEPTH_W +: IDX_W];

  always_comb begin
    if (32'(in_depth) > 32'(MAX_DEPTH)) begin
      dsat = DSAT_W'(MAX_DEPTH);
    end else begin
      dsat = DSAT_W'(in_depth);
    end
    pw = '0;
    for (int k = 0; k <= MAX_DEPTH; k++) begin
      if (32'(dsat) == k) pw = PW_W'(pow3(k));
    end
    s0_nxt.geom = geom_t'(in_tdata[GEOM_W-1:0]);
    s0_nxt.dsat = dsat;
    s0_nxt.face = in_tdata[GEOM_W + DEPTH_W + IDX_W +: FACE_W];
    if (32'(in_idx) >= 32'(pw)) begin
      s0_nxt.rem = IDX_W'(pw - 1'b1);
    end else begin
      s0_nxt.rem = in_idx;
    end
  end

  assign in_tready = !vld0_r || lv_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (in_tready) begin
      vld0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s0_r <= s0_nxt;
    end
  end

  ssg_levels u_levels (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vld0_r),
    .in_ready  (lv_ready),
    .in_data   (s0_r),
    .out_valid (lv_valid),
    .out_ready (out_tready),
    .out_data  (lv_data)
  );

  assign nrm        = face_normal(lv_data.face);
  assign out_tvalid = lv_valid;
  assign out_tdata  = {{OUT_PAD{1'b0}}, nrm, lv_data.geom};

endmodule

FILE: rtl/core/ssg_checker.sv
// ----------------------------------------------------------------------------
// ssg_checker: port-level checks for the leaf generator
// Output hold under stall, reset flush, ready after reset, and normal/padding
// field shape.
// ----------------------------------------------------------------------------
module ssg_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ssg_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import ssg_pkg::*;

  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped during stall");

  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out_tdata changed during stall");

  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // every stage is empty after reset, so the input side takes a beat
  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("in_tready low after reset");

  // normal y is always +1; exactly one of x and z is nonzero; pad is zero
  a_normal_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[147:146] == NRM_POS) && (out_tdata[151:150] == 2'b00)
                   && ((out_tdata[145:144] != NRM_ZERO) != (out_tdata[149:148] != NRM_ZERO)))
    else $error("bad normal or padding in result beat");

endmodule

bind sierpinski_subtriangle_generator_core ssg_checker u_ssg_checker (.*);

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for sierpinski_subtriangle_generator_core
// Drives root triangles with depth, leaf index and face, predicts (or takes
// from a typed table row) the leaf triangle and face normal for each beat,
// and checks every result beat field by field in order. It runs a directed
// table first, then 1450 random queries, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import ssg_pkg::*;

  localparam int IDLE_PCT    = 38;
  localparam int N_RANDOM    = 1450;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_PRINTS  = 40;

  typedef logic [2:0][COORD_W-1:0] vtx_t;

  // low to high: nine coordinates, depth, leaf index, face
  typedef struct packed {
    logic [FACE_W-1:0]            face;
    logic [IDX_W-1:0]             idx;
    logic [DEPTH_W-1:0]           depth;
    logic [8:0][COORD_W-1:0]      v;
  } query_t;

  // low to high: nine coordinates, normal x, y, z
  typedef struct packed {
    logic [2:0][NRM_W-1:0]        n;
    logic [8:0][COORD_W-1:0]      v;
  } leaf_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  leaf_t  pending_leaves[$];
  query_t row_query[$];
  bit     row_typed[$];
  leaf_t  row_leaf[$];

  bit     calm           = 1'b0;
  int     err_count      = 0;
  int     beats_sent     = 0;
  int     leaves_checked = 0;
  int     cycles         = 0;
  int     n_root         = 0;
  int     n_depth_sat    = 0;
  int     n_idx_clamp    = 0;

  string coord_names[9] = '{"top_x", "top_y", "top_z", "left_x", "left_y", "left_z",
                            "right_x", "right_y", "right_z"};
  string nrm_names[3]   = '{"normal_x", "normal_y", "normal_z"};

  sierpinski_subtriangle_generator_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d leaves pending", cycles, pending_leaves.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int leaves_at(input int d);
    int p;
    p = 1;
    for (int k = 0; k < d; k++) p = p * 3;
    return p;
  endfunction

  // depth-first leaf: base-3 digits of the index pick top/left/right child
  function automatic leaf_t predict_leaf(input query_t q);
    int    t[3], l[3], r[3];
    int    mlt[3], mrt[3], mlr[3];
    int    d, idx, p, digit;
    leaf_t lf;
    for (int i = 0; i < 3; i++) begin
      t[i] = $signed(q.v[i]);
      l[i] = $signed(q.v[3 + i]);
      r[i] = $signed(q.v[6 + i]);
    end
    d = (q.depth > MAX_DEPTH) ? MAX_DEPTH : q.depth;
    p = leaves_at(d);
    idx = (q.idx >= p) ? p - 1 : q.idx;
    for (int lvl = d; lvl > 0; lvl--) begin
      p = p / 3;
      digit = (idx / p) % 3;
      for (int i = 0; i < 3; i++) begin
        mlt[i] = (l[i] + t[i]) >>> 1;
        mrt[i] = (r[i] + t[i]) >>> 1;
        mlr[i] = (l[i] + r[i]) >>> 1;
      end
      for (int i = 0; i < 3; i++) begin
        case (digit)
          CHILD_TOP: begin
            l[i] = mlt[i];
            r[i] = mrt[i];
          end
          CHILD_LEFT: begin
            t[i] = mlt[i];
            r[i] = mlr[i];
          end
          default: begin
            t[i] = mrt[i];
            l[i] = mlr[i];
          end
        endcase
      end
    end
    for (int i = 0; i < 3; i++) begin
      lf.v[i]     = 16'(t[i]);
      lf.v[3 + i] = 16'(l[i]);
      lf.v[6 + i] = 16'(r[i]);
    end
    lf.n[1] = NRM_POS;
    case (q.face)
      FACE_RIGHT: begin
        lf.n[0] = NRM_POS;
        lf.n[2] = NRM_ZERO;
      end
      FACE_FRONT: begin
        lf.n[0] = NRM_ZERO;
        lf.n[2] = NRM_POS;
      end
      FACE_LEFT: begin
        lf.n[0] = NRM_NEG;
        lf.n[2] = NRM_ZERO;
      end
      default: begin
        lf.n[0] = NRM_ZERO;
        lf.n[2] = NRM_NEG;
      end
    endcase
    return lf;
  endfunction

  function automatic vtx_t vtx(input int x, input int y, input int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  function automatic query_t mk_query(input vtx_t t, input vtx_t l, input vtx_t r,
                                      input int depth, input int idx,
                                      input logic [FACE_W-1:0] face);
    query_t q;
    q.v     = {r, l, t};
    q.depth = DEPTH_W'(depth);
    q.idx   = IDX_W'(idx);
    q.face  = face;
    return q;
  endfunction

  function automatic leaf_t mk_leaf(input vtx_t t, input vtx_t l, input vtx_t r,
                                    input logic signed [NRM_W-1:0] nx,
                                    input logic signed [NRM_W-1:0] ny,
                                    input logic signed [NRM_W-1:0] nz);
    leaf_t lf;
    lf.v = {r, l, t};
    lf.n = {nz, ny, nx};
    return lf;
  endfunction

  task automatic add_row(input query_t q, input bit typed, input leaf_t lf);
    row_query.push_back(q);
    row_typed.push_back(typed);
    row_leaf.push_back(lf);
  endtask

  function automatic logic [COORD_W-1:0] pick_coord();
    int sel;
    sel = $urandom_range(99);
    if (sel < 80) return 16'(int'($urandom_range(32768)) - 16384);
    if (sel < 90) begin
      case ($urandom_range(2))
        0:       return 16'(-16384);
        1:       return 16'(16384);
        default: return '0;
      endcase
    end
    return 16'($urandom);
  endfunction

  task automatic gen_query(output query_t q);
    int d, span;
    for (int i = 0; i < 9; i++) q.v[i] = pick_coord();
    q.depth = DEPTH_W'($urandom_range(7));
    q.face  = FACE_W'($urandom_range(3));
    d = (q.depth > MAX_DEPTH) ? MAX_DEPTH : q.depth;
    span = leaves_at(d);
    if ($urandom_range(99) < 85) q.idx = IDX_W'($urandom_range(span - 1));
    else q.idx = IDX_W'($urandom_range(1023));
    if (q.depth == 0) n_root++;
    if (q.depth > MAX_DEPTH) n_depth_sat++;
    if (q.idx >= span) n_idx_clamp++;
  endtask

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_PRINTS) $display("MISMATCH @%0d: %s", cycles, msg);
    err_count++;
  endtask

  // one beat; the expectation is queued at the accepting edge
  task automatic send_beat(input query_t q, input leaf_t want);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'(q);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_leaves.push_back(want);
    beats_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_leaves.size() != 0) @(posedge clk);
  endtask

  task automatic check_leaf(input leaf_t got);
    leaf_t want;
    if (pending_leaves.size() == 0) begin
      report_mismatch("result beat with nothing pending");
      return;
    end
    want = pending_leaves.pop_front();
    for (int i = 0; i < 9; i++)
      if (got.v[i] !== want.v[i])
        report_mismatch($sformatf("leaf %0d %s: got %0d expected %0d", leaves_checked,
                                  coord_names[i], $signed(got.v[i]), $signed(want.v[i])));
    for (int i = 0; i < 3; i++)
      if (got.n[i] !== want.n[i])
        report_mismatch($sformatf("leaf %0d %s: got %0d expected %0d", leaves_checked,
                                  nrm_names[i], $signed(got.n[i]), $signed(want.n[i])));
    leaves_checked++;
  endtask

  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    if (rst_n && out_tvalid && out_tready) check_leaf(leaf_t'(out_tdata[OUT_BITS-1:0]));
  end

  initial begin
    vtx_t   pt, nt, zt, a, b, c;
    query_t q;
    pt = vtx(16384, 16384, 16384);
    nt = vtx(-16384, -16384, -16384);
    zt = vtx(0, 0, 0);
    a  = vtx(16384, 0, -16384);
    b  = vtx(-16384, 16384, 0);
    c  = vtx(0, -16384, 16384);

    // depth zero returns the root, index ignored
    add_row(mk_query(vtx(16384, 1, -2), vtx(-16384, 3, -4), vtx(0, 5, -6), 0, 0, FACE_RIGHT),
            1'b1, mk_leaf(vtx(16384, 1, -2), vtx(-16384, 3, -4), vtx(0, 5, -6),
                          NRM_POS, NRM_POS, NRM_ZERO));
    add_row(mk_query(vtx(100, -200, 300), vtx(-400, 500, -600), vtx(700, -800, 900),
                     0, 1023, FACE_FRONT),
            1'b1, mk_leaf(vtx(100, -200, 300), vtx(-400, 500, -600), vtx(700, -800, 900),
                          NRM_ZERO, NRM_POS, NRM_POS));
    // degenerate triangles stay put at any depth
    add_row(mk_query(pt, pt, pt, 6, 728, FACE_LEFT),
            1'b1, mk_leaf(pt, pt, pt, NRM_NEG, NRM_POS, NRM_ZERO));
    add_row(mk_query(nt, nt, nt, 7, 1023, FACE_BACK),
            1'b1, mk_leaf(nt, nt, nt, NRM_ZERO, NRM_POS, NRM_NEG));
    add_row(mk_query(vtx(32767, 32767, 32767), vtx(32767, 32767, 32767),
                     vtx(32767, 32767, 32767), 7, 0, FACE_RIGHT),
            1'b1, mk_leaf(vtx(32767, 32767, 32767), vtx(32767, 32767, 32767),
                          vtx(32767, 32767, 32767), NRM_POS, NRM_POS, NRM_ZERO));
    add_row(mk_query(vtx(-32768, -32768, -32768), vtx(-32768, -32768, -32768),
                     vtx(-32768, -32768, -32768), 6, 364, FACE_FRONT),
            1'b1, mk_leaf(vtx(-32768, -32768, -32768), vtx(-32768, -32768, -32768),
                          vtx(-32768, -32768, -32768), NRM_ZERO, NRM_POS, NRM_POS));
    // each child, clamped indices, saturated depth, rounding, full scale
    add_row(mk_query(pt, nt, zt, 1, 0, FACE_RIGHT), 1'b0, '0);
    add_row(mk_query(pt, nt, zt, 1, 1, FACE_FRONT), 1'b0, '0);
    add_row(mk_query(pt, nt, zt, 1, 2, FACE_LEFT), 1'b0, '0);
    add_row(mk_query(pt, nt, zt, 1, 3, FACE_BACK), 1'b0, '0);
    add_row(mk_query(a, b, c, 2, 8, FACE_RIGHT), 1'b0, '0);
    add_row(mk_query(a, b, c, 2, 9, FACE_FRONT), 1'b0, '0);
    add_row(mk_query(a, b, c, 6, 729, FACE_LEFT), 1'b0, '0);
    add_row(mk_query(a, b, c, 6, 0, FACE_BACK), 1'b0, '0);
    add_row(mk_query(a, b, c, 5, 242, FACE_RIGHT), 1'b0, '0);
    add_row(mk_query(a, b, c, 3, 13, FACE_FRONT), 1'b0, '0);
    add_row(mk_query(vtx(-1, -1, 1), vtx(-2, 0, 0), vtx(1, -3, 2), 1, 1, FACE_LEFT),
            1'b0, '0);
    add_row(mk_query(vtx(32767, -32768, 32767), vtx(-32768, 32767, -32768),
                     vtx(32767, 32767, -32768), 6, 364, FACE_BACK), 1'b0, '0);
    add_row(mk_query(c, a, b, 4, 1023, FACE_RIGHT), 1'b0, '0);
    add_row(mk_query(b, c, a, 7, 512, FACE_FRONT), 1'b0, '0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (row_query[i])
      send_beat(row_query[i], row_typed[i] ? row_leaf[i] : predict_leaf(row_query[i]));
    // hold off until the pipe is empty
    drain();

    for (int n = 0; n < N_RANDOM; n++) begin
      calm = (n >= 600 && n < 850);
      gen_query(q);
      send_beat(q, predict_leaf(q));
    end
    calm = 1'b0;
    drain();
    repeat (3 * (MAX_DEPTH + 1)) @(posedge clk);

    $display("sent %0d beats (%0d directed), checked %0d leaves, %0d mismatches",
             beats_sent, row_query.size(), leaves_checked, err_count);
    $display("random part: %0d root-only, %0d saturated depth, %0d clamped index",
             n_root, n_depth_sat, n_idx_clamp);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/ssg_pkg.sv
rtl/core/ssg_levels.sv
rtl/core/sierpinski_subtriangle_generator_core.sv
rtl/core/ssg_checker.sv
bench/tb_top.sv
